FILE: src/dq_pkg.sv
`timescale 1ns / 1ps
package dq_pkg;

   localparam int MODE_W   = 4;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 10;
   localparam int ROT_W    = 16;
   localparam int STATUS_W = 2;
   localparam int LENGTH_W = 11;
   localparam int DIV_CNT_W = $clog2(ROT_W);

   localparam logic [MODE_W-1:0] MODE_PUSH_RIGHT = 4'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_LEFT  = 4'd1;
   localparam logic [MODE_W-1:0] MODE_POP_RIGHT  = 4'd2;
   localparam logic [MODE_W-1:0] MODE_POP_LEFT   = 4'd3;
   localparam logic [MODE_W-1:0] MODE_READ       = 4'd4;
   localparam logic [MODE_W-1:0] MODE_WRITE      = 4'd5;
   localparam logic [MODE_W-1:0] MODE_DELETE     = 4'd6;
   localparam logic [MODE_W-1:0] MODE_ROTATE     = 4'd7;
   localparam logic [MODE_W-1:0] MODE_CLEAR      = 4'd8;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic decode;
      logic div_step;
      logic rot_setup;
      logic mv_read;
      logic mv_write;
      logic rd_capture;
      logic out_load;
   } dq_cmd_type;

   typedef struct packed {
      logic go_read;
      logic go_div;
      logic go_move;
      logic div_last;
      logic mv_last;
      logic out_free;
   } dq_status_type;

endpackage

FILE: src/dq_req_if.sv
`timescale 1ns / 1ps
interface dq_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  mode;
   logic [31:0] value_in;
   logic [9:0]  position;
   logic signed [15:0] rotate_by;

   modport source (output valid, mode, value_in, position, rotate_by, input ready);
   modport sink   (input valid, mode, value_in, position, rotate_by, output ready);
endinterface

FILE: src/dq_rsp_if.sv
`timescale 1ns / 1ps
interface dq_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value_out;
   logic [1:0]  status;
   logic [10:0] length;

   modport source (output valid, value_out, status, length, input ready);
   modport sink   (input valid, value_out, status, length, output ready);
endinterface

FILE: src/dq_ram.sv
`timescale 1ns / 1ps
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: src/dq_ctrl.sv
`timescale 1ns / 1ps
module dq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  dq_pkg::dq_status_type st,
   output dq_pkg::dq_cmd_type    cmd
);
   import dq_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_DECODE  = 8'b0000_0010,
      S_RD_WAIT = 8'b0000_0100,
      S_DIV     = 8'b0000_1000,
      S_ROT_SET = 8'b0001_0000,
      S_MV_RD   = 8'b0010_0000,
      S_MV_WR   = 8'b0100_0000,
      S_DONE    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign in_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            if (st.go_div) begin
               state_in = S_DIV;
            end else if (st.go_move) begin
               state_in = S_MV_RD;
            end else if (st.go_read) begin
               state_in = S_RD_WAIT;
            end else if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RD_WAIT: begin
            cmd.rd_capture = 1'b1;
            state_in       = S_DONE;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_last) begin
               state_in = S_ROT_SET;
            end
         end
         S_ROT_SET: begin
            cmd.rot_setup = 1'b1;
            state_in      = st.go_move ? S_MV_RD : S_DONE;
         end
         S_MV_RD: begin
            cmd.mv_read = 1'b1;
            state_in    = S_MV_WR;
         end
         S_MV_WR: begin
            cmd.mv_write = 1'b1;
            state_in     = st.mv_last ? S_DONE : S_MV_RD;
         end
         S_DONE: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/dq_datapath.sv
`timescale 1ns / 1ps
module dq_datapath #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dq_pkg::dq_cmd_type            cmd,
   output dq_pkg::dq_status_type         st,
   input  logic [dq_pkg::MODE_W-1:0]     in_mode,
   input  logic [dq_pkg::VALUE_W-1:0]    in_value,
   input  logic [dq_pkg::POS_W-1:0]      in_position,
   input  logic signed [dq_pkg::ROT_W-1:0] in_rotate_by,
   input  logic                          out_ready,
   output logic                          out_valid,
   output logic [dq_pkg::VALUE_W-1:0]    out_value,
   output logic [dq_pkg::STATUS_W-1:0]   out_status,
   output logic [dq_pkg::LENGTH_W-1:0]   out_length
);
   import dq_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   logic [MODE_W-1:0]     mode_ff;
   logic [DATA_WIDTH-1:0] val_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [ROT_W-1:0]      rot_ff;

   logic [PW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] steps_ff, steps_in;
   logic [PW-1:0] src_ff, src_in, dst_ff, dst_in;
   logic          up_ff, up_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [ROT_W-1:0] quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [VALUE_W-1:0]  res_val_ff, res_val_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                out_valid_ff;

   logic                  wr_en, rd_en;
   logic [PW-1:0]         wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] wr_data, rd_data;

   function automatic logic [PW-1:0] slot(input logic [PW-1:0] h, input logic [CW-1:0] i);
      logic [SW-1:0] s;
      s = SW'(h) + SW'(i);
      if (s >= SW'(DEPTH)) begin
         s = s - SW'(DEPTH);
      end
      return PW'(s);
   endfunction

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
      return (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
   endfunction

   dq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   logic [PW-1:0]    tail_slot, end_slot, pos_slot, head_dec, head_inc;
   logic             full, empty, in_range, rot_neg;
   logic [ROT_W-1:0] mag;
   logic [CW-1:0]    half, amt;
   logic             amt_up, rot_now;
   logic [SW-1:0]    head_sub, head_add;
   logic [CW:0]      div_t;

   always_comb begin
      tail_slot = slot(head_ff, count_ff - 1'b1);
      end_slot  = slot(head_ff, count_ff);
      pos_slot  = slot(head_ff, CW'(pos_ff));
      head_dec  = ptr_dec(head_ff);
      head_inc  = ptr_inc(head_ff);
      full      = (count_ff == CW'(DEPTH));
      empty     = (count_ff == '0);
      in_range  = (32'(pos_ff) < 32'(count_ff));
      rot_neg   = rot_ff[ROT_W-1];
      mag       = rot_neg ? (~rot_ff + 1'b1) : rot_ff;
      half      = CW'((SW'(count_ff) + 1'b1) >> 1);
      div_t     = {rem_ff, quo_ff[ROT_W-1]};

      // After the modulo, an amount past half the length turns the other way round.
      if (cmd.rot_setup) begin
         if (rem_ff > half) begin
            amt    = count_ff - rem_ff;
            amt_up = ~rot_neg;
         end else begin
            amt    = rem_ff;
            amt_up = rot_neg;
         end
      end else begin
         amt    = CW'(mag);
         amt_up = rot_neg;
      end
      head_sub = SW'(head_ff) + SW'(DEPTH) - SW'(amt);
      if (head_sub >= SW'(DEPTH)) begin
         head_sub = head_sub - SW'(DEPTH);
      end
      head_add = SW'(head_ff) + SW'(amt);
      if (head_add >= SW'(DEPTH)) begin
         head_add = head_add - SW'(DEPTH);
      end
   end

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      steps_in      = steps_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      up_in         = up_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      div_cnt_in    = div_cnt_ff;
      res_val_in    = res_val_ff;
      res_status_in = res_status_ff;
      wr_en         = 1'b0;
      wr_addr       = dst_ff;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = src_ff;
      st            = '0;
      st.out_free   = ~out_valid_ff | out_ready;
      st.div_last   = (div_cnt_ff == DIV_CNT_W'(ROT_W - 1));
      st.mv_last    = (steps_ff == CW'(1));
      rot_now       = 1'b0;

      if (cmd.decode) begin
         res_val_in    = '0;
         res_status_in = STATUS_OK;
         case (mode_ff)
            MODE_PUSH_RIGHT: begin
               if (full) begin
                  res_status_in = STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = end_slot;
                  wr_data  = val_ff;
                  count_in = count_ff + 1'b1;
               end
            end
            MODE_PUSH_LEFT: begin
               if (full) begin
                  res_status_in = STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = head_dec;
                  wr_data  = val_ff;
                  head_in  = head_dec;
                  count_in = count_ff + 1'b1;
               end
            end
            MODE_POP_RIGHT: begin
               if (empty) begin
                  res_status_in = STATUS_EMPTY;
               end else begin
                  rd_en      = 1'b1;
                  rd_addr    = tail_slot;
                  count_in   = count_ff - 1'b1;
                  st.go_read = 1'b1;
               end
            end
            MODE_POP_LEFT: begin
               if (empty) begin
                  res_status_in = STATUS_EMPTY;
               end else begin
                  rd_en      = 1'b1;
                  rd_addr    = head_ff;
                  head_in    = head_inc;
                  count_in   = count_ff - 1'b1;
                  st.go_read = 1'b1;
               end
            end
            MODE_READ: begin
               if (!in_range) begin
                  res_status_in = STATUS_RANGE;
               end else begin
                  rd_en      = 1'b1;
                  rd_addr    = pos_slot;
                  st.go_read = 1'b1;
               end
            end
            MODE_WRITE: begin
               if (!in_range) begin
                  res_status_in = STATUS_RANGE;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = pos_slot;
                  wr_data = val_ff;
               end
            end
            MODE_DELETE: begin
               if (!in_range) begin
                  res_status_in = STATUS_RANGE;
               end else begin
                  count_in = count_ff - 1'b1;
                  dst_in   = pos_slot;
                  // Close the gap from whichever side holds fewer entries; on a tie the entries after it move.
                  if ((SW'(pos_ff) << 1) + 1'b1 < SW'(count_ff)) begin
                     src_in   = ptr_dec(pos_slot);
                     up_in    = 1'b0;
                     steps_in = CW'(pos_ff);
                     head_in  = head_inc;
                  end else begin
                     src_in   = ptr_inc(pos_slot);
                     up_in    = 1'b1;
                     steps_in = count_ff - 1'b1 - CW'(pos_ff);
                  end
                  st.go_move = (steps_in != '0);
               end
            end
            MODE_ROTATE: begin
               if (!empty) begin
                  if (SW'(mag) > SW'(half)) begin
                     rem_in     = '0;
                     quo_in     = mag;
                     div_cnt_in = '0;
                     st.go_div  = 1'b1;
                  end else begin
                     rot_now = 1'b1;
                  end
               end
            end
            MODE_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.div_step) begin
         rem_in     = (div_t >= (CW + 1)'(count_ff)) ? CW'(div_t - (CW + 1)'(count_ff))
                                                    : CW'(div_t);
         quo_in     = quo_ff << 1;
         div_cnt_in = div_cnt_ff + 1'b1;
      end

      if (rot_now || cmd.rot_setup) begin
         steps_in   = amt;
         up_in      = amt_up;
         st.go_move = (amt != '0);
         if (amt_up) begin
            src_in  = head_ff;
            dst_in  = end_slot;
            head_in = PW'(head_add);
         end else begin
            src_in  = tail_slot;
            dst_in  = head_dec;
            head_in = PW'(head_sub);
         end
      end

      if (cmd.mv_read) begin
         rd_en   = 1'b1;
         rd_addr = src_ff;
      end

      if (cmd.mv_write) begin
         wr_en    = 1'b1;
         wr_addr  = dst_ff;
         wr_data  = rd_data;
         src_in   = up_ff ? ptr_inc(src_ff) : ptr_dec(src_ff);
         dst_in   = up_ff ? ptr_inc(dst_ff) : ptr_dec(dst_ff);
         steps_in = steps_ff - 1'b1;
      end

      if (cmd.rd_capture) begin
         res_val_in = VALUE_W'(rd_data);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= in_mode;
         val_ff  <= DATA_WIDTH'(in_value);
         pos_ff  <= in_position;
         rot_ff  <= in_rotate_by;
      end
      steps_ff      <= steps_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      up_ff         <= up_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      div_cnt_ff    <= div_cnt_in;
      res_val_ff    <= res_val_in;
      res_status_ff <= res_status_in;
      if (cmd.out_load) begin
         out_value  <= res_val_in;
         out_status <= res_status_in;
         out_length <= LENGTH_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign out_valid = out_valid_ff;

endmodule

FILE: src/double_ended_queue_core.sv
// Push, write, clear, error cases and rotates that move no entry go from decode straight to the
// result; a new request is taken only in the idle state, after the previous result is loaded.
// Pop and read add a wait state for the registered store read, in which the word is captured.
// Delete and rotate spend a read state and a write state per moved entry on the store;
// a rotate amount past half the length first runs the 16-step modulo.
// Reset is synchronous: it empties the queue and clears control; store contents stay undefined.
`timescale 1ns / 1ps
module double_ended_queue_core #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input logic      clock,
   input logic      reset,
   dq_req_if.sink   req_ch,
   dq_rsp_if.source rsp_ch
);
   import dq_pkg::*;

   dq_cmd_type    cmd;
   dq_status_type st;

   dq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .in_valid(req_ch.valid),
      .in_ready(req_ch.ready),
      .st      (st),
      .cmd     (cmd)
   );

   dq_datapath #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .st          (st),
      .in_mode     (req_ch.mode),
      .in_value    (req_ch.value_in),
      .in_position (req_ch.position),
      .in_rotate_by(req_ch.rotate_by),
      .out_ready   (rsp_ch.ready),
      .out_valid   (rsp_ch.valid),
      .out_value   (rsp_ch.value_out),
      .out_status  (rsp_ch.status),
      .out_length  (rsp_ch.length)
   );

endmodule

FILE: bench/double_ended_queue_core_tb.sv
`timescale 1ns / 1ps
module double_ended_queue_core_tb;
   import dq_pkg::*;

   localparam int DEPTH       = 1024;
   localparam int RANDOM_BEATS = 200;
   localparam int CALM_FROM   = 170;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 50000;
   localparam int DRAIN_WAIT  = 2400;
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = MODE_CLEAR + 4'd1;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 4'd15;

   typedef struct packed {
      logic [VALUE_W-1:0]  value_out;
      logic [STATUS_W-1:0] status;
      logic [LENGTH_W-1:0] length;
   } dq_result_type;

   typedef struct {
      logic [MODE_W-1:0]       mode;
      logic [VALUE_W-1:0]      value_in;
      logic [POS_W-1:0]        position;
      logic signed [ROT_W-1:0] rotate_by;
      bit                      typed;
      dq_result_type           result;
   } dq_row_type;

   logic clock = 1'b0;
   logic reset;

   dq_req_if req_ch ();
   dq_rsp_if rsp_ch ();

   double_ended_queue_core #(.DEPTH(DEPTH), .DATA_WIDTH(VALUE_W)) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the queue: ring store, head slot and occupancy.
   logic [VALUE_W-1:0] ring [DEPTH];
   int unsigned        head_slot;
   int unsigned        occupancy;

   dq_result_type pending_results[$];
   int            errors;
   bit            calm;
   bit            hold_request;
   bit            holding;
   bit            sender_busy;

   function automatic int unsigned ring_slot(int unsigned idx);
      return (head_slot + idx) % DEPTH;
   endfunction

   function automatic void head_back();
      head_slot = (head_slot == 0) ? DEPTH - 1 : head_slot - 1;
   endfunction

   function automatic void head_fwd();
      head_slot = (head_slot + 1 >= DEPTH) ? 0 : head_slot + 1;
   endfunction

   function automatic dq_result_type apply_request(logic [MODE_W-1:0] mode,
                                                   logic [VALUE_W-1:0] value,
                                                   logic [POS_W-1:0] pos,
                                                   logic signed [ROT_W-1:0] rot);
      dq_result_type r;
      int         len;
      int         half;
      int         steps;
      int unsigned p;
      logic [VALUE_W-1:0] w;
      r = '0;
      p = pos;
      case (mode)
         MODE_PUSH_RIGHT, MODE_PUSH_LEFT: begin
            if (occupancy >= DEPTH) begin
               r.status = STATUS_FULL;
            end else if (mode == MODE_PUSH_RIGHT) begin
               ring[ring_slot(occupancy)] = value;
               occupancy++;
            end else begin
               head_back();
               ring[head_slot] = value;
               occupancy++;
            end
         end
         MODE_POP_RIGHT, MODE_POP_LEFT: begin
            if (occupancy == 0) begin
               r.status = STATUS_EMPTY;
            end else if (mode == MODE_POP_RIGHT) begin
               r.value_out = ring[ring_slot(occupancy - 1)];
               occupancy--;
            end else begin
               r.value_out = ring[head_slot];
               head_fwd();
               occupancy--;
            end
         end
         MODE_READ, MODE_WRITE, MODE_DELETE: begin
            if (p >= occupancy) begin
               r.status = STATUS_RANGE;
            end else if (mode == MODE_READ) begin
               r.value_out = ring[ring_slot(p)];
            end else if (mode == MODE_WRITE) begin
               ring[ring_slot(p)] = value;
            end else begin
               // The shorter side closes the gap.
               if (p < occupancy - 1 - p) begin
                  for (int unsigned i = p; i > 0; i--)
                     ring[ring_slot(i)] = ring[ring_slot(i - 1)];
                  head_fwd();
               end else begin
                  for (int unsigned i = p; i + 1 < occupancy; i++)
                     ring[ring_slot(i)] = ring[ring_slot(i + 1)];
               end
               occupancy--;
            end
         end
         MODE_ROTATE: begin
            len = occupancy;
            half = (len + 1) >> 1;
            steps = rot;
            if (len != 0) begin
               if (steps > half || steps < -half) begin
                  steps = steps % len;
                  if (steps > half) steps -= len;
                  else if (steps < -half) steps += len;
               end
               for (int k = 0; k < steps; k++) begin
                  w = ring[ring_slot(occupancy - 1)];
                  head_back();
                  ring[head_slot] = w;
               end
               for (int k = 0; k > steps; k--) begin
                  w = ring[head_slot];
                  ring[ring_slot(occupancy)] = w;
                  head_fwd();
               end
            end
         end
         MODE_CLEAR: occupancy = 0;
         default: ;
      endcase
      r.length = LENGTH_W'(occupancy);
      return r;
   endfunction

   // Offers one request and holds it until the block takes it.
   task automatic send_request(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value,
                               logic [POS_W-1:0] pos, logic signed [ROT_W-1:0] rot,
                               bit typed = 0, dq_result_type typed_result = '0);
      dq_result_type predicted;
      int         gap;
      req_ch.valid     <= 1'b1;
      req_ch.mode      <= mode;
      req_ch.value_in  <= value;
      req_ch.position  <= pos;
      req_ch.rotate_by <= rot;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = apply_request(mode, value, pos, rot);
      pending_results.push_back(typed ? typed_result : predicted);
      if (!calm && !sender_busy && $urandom_range(0, 9) < 2) begin
         gap = $urandom_range(1, 15);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic pause_sender();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [POS_W-1:0] pick_position();
      if (occupancy == 0 || $urandom_range(0, 9) == 0)
         return POS_W'($urandom_range(0, DEPTH - 1));
      return POS_W'($urandom_range(0, occupancy - 1));
   endfunction

   function automatic logic signed [ROT_W-1:0] pick_rotation();
      case ($urandom_range(0, 3))
         0: return $signed(16'($urandom_range(0, 65535)));
         1: return $signed(16'($urandom_range(0, 6))) - 16'sd3;
         default: return $signed(16'($urandom_range(0, 2 * occupancy + 2))) -
                         $signed(16'(occupancy + 1));
      endcase
   endfunction

   // Result side: random stall bursts, plus one long hold-off on request.
   initial begin
      int burst;
      rsp_ch.ready <= 1'b0;
      holding = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 0;
            holding = 1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holding = 0;
            rsp_ch.ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 15);
            rsp_ch.ready <= 1'b0;
            repeat (burst) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      dq_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat value_out=%h status=%0d length=%0d",
                     $time, rsp_ch.value_out, rsp_ch.status, rsp_ch.length);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.value_out !== want.value_out) begin
               $display("%0t: value_out expected %h actual %h",
                        $time, want.value_out, rsp_ch.value_out);
               errors++;
            end
            if (rsp_ch.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_ch.status);
               errors++;
            end
            if (rsp_ch.length !== want.length) begin
               $display("%0t: length expected %0d actual %0d",
                        $time, want.length, rsp_ch.length);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a beat.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   dq_row_type directed [] = '{
      '{MODE_POP_RIGHT,  32'h0,        10'd0,    16'sd0,      1, '{32'h0, STATUS_EMPTY, 11'd0}},
      '{MODE_POP_LEFT,   32'h0,        10'd0,    16'sd0,      1, '{32'h0, STATUS_EMPTY, 11'd0}},
      '{MODE_READ,       32'h0,        10'd0,    16'sd0,      1, '{32'h0, STATUS_RANGE, 11'd0}},
      '{MODE_WRITE,      32'h1234,     10'd1023, 16'sd0,      1, '{32'h0, STATUS_RANGE, 11'd0}},
      '{MODE_DELETE,     32'h0,        10'd0,    16'sd0,      1, '{32'h0, STATUS_RANGE, 11'd0}},
      '{MODE_ROTATE,     32'h0,        10'd0,    16'sd5,      1, '{32'h0, STATUS_OK,    11'd0}},
      '{MODE_SPARE_LO,   32'hFFFFFFFF, 10'd1023, -16'sd1,     1, '{32'h0, STATUS_OK,    11'd0}},
      '{MODE_SPARE_HI,   32'hFFFFFFFF, 10'd1023, 16'sd32767,  1, '{32'h0, STATUS_OK,    11'd0}},
      '{MODE_PUSH_RIGHT, 32'hFFFFFFFF, 10'd0,    16'sd0,      1, '{32'h0, STATUS_OK,    11'd1}},
      '{MODE_PUSH_LEFT,  32'h00000000, 10'd0,    16'sd0,      1, '{32'h0, STATUS_OK,    11'd2}},
      '{MODE_PUSH_RIGHT, 32'hA5A5A5A5, 10'd0,    16'sd0,      0, '0},
      '{MODE_PUSH_LEFT,  32'h5A5A5A5A, 10'd0,    16'sd0,      0, '0},
      '{MODE_READ,       32'h0,        10'd1,    16'sd0,      0, '0},
      '{MODE_READ,       32'h0,        10'd1023, 16'sd0,      1, '{32'h0, STATUS_RANGE, 11'd4}},
      '{MODE_WRITE,      32'hDEADBEEF, 10'd3,    16'sd0,      0, '0},
      '{MODE_ROTATE,     32'h0,        10'd0,    16'sd1,      0, '0},
      '{MODE_ROTATE,     32'h0,        10'd0,    -16'sd1,     0, '0},
      '{MODE_ROTATE,     32'h0,        10'd0,    16'sd32767,  0, '0},
      '{MODE_ROTATE,     32'h0,        10'd0,    -16'sd32768, 0, '0},
      '{MODE_DELETE,     32'h0,        10'd2,    16'sd0,      0, '0},
      '{MODE_DELETE,     32'h0,        10'd0,    16'sd0,      0, '0},
      '{MODE_POP_RIGHT,  32'h0,        10'd0,    16'sd0,      0, '0},
      '{MODE_POP_LEFT,   32'h0,        10'd0,    16'sd0,      0, '0},
      '{MODE_PUSH_RIGHT, 32'h0000FFFF, 10'd0,    16'sd0,      0, '0},
      '{MODE_CLEAR,      32'h0,        10'd0,    16'sd0,      1, '{32'h0, STATUS_OK,    11'd0}}
   };

   initial begin
      int unsigned pick;
      logic [MODE_W-1:0] mode;
      errors = 0;
      calm = 0;
      hold_request = 0;
      sender_busy = 0;
      head_slot = 0;
      occupancy = 0;
      reset <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.mode      <= MODE_CLEAR;
      req_ch.value_in  <= '0;
      req_ch.position  <= '0;
      req_ch.rotate_by <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_request(directed[i].mode, directed[i].value_in, directed[i].position,
                      directed[i].rotate_by, directed[i].typed, directed[i].result);

      // Fill to the top while the result side first holds off, then push past full.
      sender_busy = 1;
      hold_request = 1;
      for (int i = 0; i < DEPTH + 2; i++)
         send_request($urandom_range(0, 1) ? MODE_PUSH_RIGHT : MODE_PUSH_LEFT,
                      $urandom, 10'd0, 16'sd0);
      sender_busy = 0;
      send_request(MODE_READ, 32'h0, 10'd1023, 16'sd0);
      send_request(MODE_WRITE, $urandom, 10'd1023, 16'sd0);
      send_request(MODE_ROTATE, 32'h0, 10'd0, 16'sd32767);
      send_request(MODE_ROTATE, 32'h0, 10'd0, -16'sd513);
      send_request(MODE_DELETE, 32'h0, 10'd1023, 16'sd0);
      send_request(MODE_DELETE, 32'h0, 10'd1, 16'sd0);
      send_request(MODE_READ, 32'h0, 10'd0, 16'sd0);
      send_request(MODE_CLEAR, 32'h0, 10'd0, 16'sd0);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n == RANDOM_BEATS / 2) begin
            // Let every outstanding result come back before going on.
            pause_sender();
            while (pending_results.size() != 0) @(posedge clock);
         end
         calm = (n >= CALM_FROM);
         pick = $urandom_range(0, 99);
         if (pick < 30)      mode = pick < 15 ? MODE_PUSH_RIGHT : MODE_PUSH_LEFT;
         else if (pick < 50) mode = pick < 40 ? MODE_POP_RIGHT : MODE_POP_LEFT;
         else if (pick < 62) mode = MODE_READ;
         else if (pick < 72) mode = MODE_WRITE;
         else if (pick < 80) mode = MODE_DELETE;
         else if (pick < 95) mode = MODE_ROTATE;
         else if (pick < 97) mode = MODE_CLEAR;
         else                mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
         if (occupancy < 3 && pick >= 30 && pick < 50)
            mode = MODE_PUSH_LEFT;
         else if (occupancy > 60 && pick < 30)
            mode = MODE_POP_RIGHT;
         send_request(mode, $urandom, pick_position(), pick_rotation());
      end
      pause_sender();

      while (pending_results.size() != 0 || holding) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
